// ----- hdl/bmp_stream_decoder_core_defines.svh -----
// Assertion macros for the decoder core.
`ifndef BMP_STREAM_DECODER_CORE_DEFINES_SVH
`define BMP_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BSD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) pre |=> post) else $error(msg);
`else
`define BSD_ASSERT(lbl, prop, msg)
`define BSD_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- hdl/bmpsd_pkg.sv -----
`timescale 1ns / 1ps

package bmpsd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_DIBSKIP = 3'd1,
        PH_PALETTE = 3'd2,
        PH_GAP     = 3'd3,
        PH_PIXELS  = 3'd4,
        PH_IDLE    = 3'd5
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROC,
        ST_PIX_RD,
        ST_PIX_OUT,
        ST_ROW,
        ST_LIM1,
        ST_LIM2,
        ST_SETTLE,
        ST_ERR
    } state_t;

    localparam logic [1:0] STATUS_PIXEL   = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIG = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR = 2'd2;

    localparam logic [31:0] POS_SIG     = 32'd1;
    localparam logic [31:0] POS_DATAOFF = 32'd13;
    localparam logic [31:0] POS_DIBSIZE = 32'd17;
    localparam logic [31:0] POS_WIDTH   = 32'd21;
    localparam logic [31:0] POS_HEIGHT  = 32'd25;
    localparam logic [31:0] POS_BPP     = 32'd29;
    localparam logic [31:0] POS_PALCNT  = 32'd49;
    localparam logic [31:0] POS_LAST    = 32'd53;

    localparam logic [32:0] HEADER_BYTES = 33'd54;
    localparam logic [31:0] BASE_DIB     = 32'h28;
    localparam logic [7:0]  SIG_B        = 8'h42;
    localparam logic [7:0]  SIG_M        = 8'h4d;
    localparam logic [31:0] OPAQUE       = 32'hff000000;

endpackage

// ----- hdl/bmp_stream_decoder_core.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                           Direction
// s_        s_valid s_ready s_file_byte s_start_req         in  (one file byte per item)
// m_        m_valid m_ready m_status m_pixel_abgr           out (pixel or error result)
//           m_pixel_column m_pixel_row m_alpha_seen m_image_done m_last
//
// A header, palette or skipped byte passes through accept, process and settle steps; the last
// header byte adds the skip-limit steps ST_LIM1 and ST_LIM2, and each phase change while settling adds a settle step.
// Each pixel passes through a read step (the palette RAM read for palette pixels) and an
// output step; every pixel byte then takes a row step before it settles.
// s_ready is high only between bytes. Output stalls hold the sequencer.
// aresetn is synchronous, active low; no clearing pass is needed.
`include "bmp_stream_decoder_core_defines.svh"

module bmp_stream_decoder_core
    import bmpsd_pkg::*;
#(
    parameter int MAX_DIM       = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    input  logic        s_start_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_pixel_abgr,
    output logic [11:0] m_pixel_column,
    output logic [11:0] m_pixel_row,
    output logic        m_alpha_seen,
    output logic        m_image_done,
    output logic        m_last
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int RBC_W = DIM_W + 2;
    localparam int PW    = DIM_W + 7;
    localparam int AW    = $clog2(PALETTE_DEPTH);

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic [31:0]      file_off_reg, p_reg, hshift_reg, dib_size_reg, data_off_reg;
    logic [7:0]       byte_reg;
    logic [DIM_W-1:0] width_reg, height_reg, col_reg, row_reg;
    logic [5:0]       bpp_reg;
    logic [8:0]       pal_cnt_reg;
    logic [32:0]      dib_end_reg;
    logic [33:0]      pal_end_reg;
    logic [PW-1:0]    stride_reg;
    logic [1:0]       pal_k_reg, mod3_reg, err_reg;
    logic [7:0]       pal_ent_reg;
    logic [RBC_W-1:0] rbc_reg;
    logic [23:0]      partial_reg, rd_data_reg;
    logic             any_alpha_reg, direct_reg, oob_reg, px_alpha_reg;
    logic [2:0]       j_reg, jlast_reg;
    logic [31:0]      pix_reg;

    logic [23:0] pal_mem [PALETTE_DEPTH];

    logic        m_valid_reg, m_last_reg, m_alpha_reg, m_done_reg;
    logic [1:0]  m_status_reg;
    logic [31:0] m_abgr_reg;
    logic [11:0] m_col_reg, m_row_reg;

    // combinational helpers
    logic        accept, out_free, in_img, done, px_last, sig_bad, hdr_bad, settle_move;
    logic        small_bpp, pix_now, m_load;
    logic [31:0] hs_new;
    logic [7:0]  idx8;
    logic [DIM_W:0] col_inc;
    logic [PW-1:0]  stride_calc;

    function automatic logic [DIM_W-1:0] dim_check(input logic [31:0] v);
        logic [DIM_W-1:0] r;
        r = '0;
        if (!v[31] && v != 32'd0 && v <= 32'(MAX_DIM)) begin
            r = v[DIM_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        accept      = s_valid && s_ready;
        out_free    = !m_valid_reg || m_ready;
        m_load      = out_free && (state_reg == ST_PIX_OUT || state_reg == ST_ERR);
        hs_new      = {byte_reg, hshift_reg[31:8]};
        sig_bad     = (p_reg == POS_SIG) && (hs_new[23:16] != SIG_B || hs_new[31:24] != SIG_M);
        hdr_bad     = (p_reg == POS_LAST) &&
                      (width_reg == '0 || height_reg == '0 || bpp_reg == 6'd0);
        in_img      = (col_reg < width_reg) && (row_reg < height_reg);
        col_inc     = {1'b0, col_reg} + (DIM_W + 1)'(1);
        done        = ({1'b0, row_reg} + (DIM_W + 1)'(1) == {1'b0, height_reg}) &&
                      (col_inc == {1'b0, width_reg});
        px_last     = (j_reg == jlast_reg) || (col_inc >= {1'b0, width_reg}) || done;
        small_bpp   = (bpp_reg == 6'd1) || (bpp_reg == 6'd4) || (bpp_reg == 6'd8);
        pix_now     = small_bpp ||
                      (bpp_reg == 6'd24 && mod3_reg == 2'd2) ||
                      (bpp_reg == 6'd32 && rbc_reg[1:0] == 2'd3 && col_reg < width_reg);
        settle_move = (phase_reg == PH_DIBSKIP && {1'b0, file_off_reg} >= dib_end_reg) ||
                      (phase_reg == PH_PALETTE && {2'b0, file_off_reg} >= pal_end_reg) ||
                      (phase_reg == PH_GAP && file_off_reg >= data_off_reg);
        stride_calc = PW'((PW'(width_reg) * PW'(bpp_reg) + PW'(31)) >> 5) << 2;
        unique case (bpp_reg)
            6'd1:    idx8 = {7'd0, byte_reg[3'd7 - j_reg]};
            6'd4:    idx8 = (j_reg == 3'd0) ? {4'd0, byte_reg[7:4]} : {4'd0, byte_reg[3:0]};
            default: idx8 = byte_reg;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_PROC;
            ST_PROC: begin
                unique case (phase_reg)
                    PH_HEADER: begin
                        if (sig_bad || hdr_bad)      state_next = ST_ERR;
                        else if (p_reg == POS_LAST)  state_next = ST_LIM1;
                        else                         state_next = ST_SETTLE;
                    end
                    PH_PIXELS:  state_next = pix_now ? ST_PIX_RD : ST_ROW;
                    default:    state_next = ST_SETTLE;
                endcase
            end
            ST_PIX_RD:  state_next = in_img ? ST_PIX_OUT : ST_ROW;
            ST_PIX_OUT: if (out_free) state_next = px_last ? ST_ROW : ST_PIX_RD;
            ST_ROW:     state_next = ST_SETTLE;
            ST_LIM1:    state_next = ST_LIM2;
            ST_LIM2:    state_next = ST_SETTLE;
            ST_SETTLE:  state_next = settle_move ? ST_SETTLE : ST_IDLE;
            ST_ERR:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        m_valid        = m_valid_reg;
        m_status       = m_status_reg;
        m_pixel_abgr   = m_abgr_reg;
        m_pixel_column = m_col_reg;
        m_pixel_row    = m_row_reg;
        m_alpha_seen   = m_alpha_reg;
        m_image_done   = m_done_reg;
        m_last         = m_last_reg;
    end

    // palette RAM
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PROC && phase_reg == PH_PALETTE && pal_k_reg == 2'd2) begin
            pal_mem[pal_ent_reg[AW-1:0]] <= {partial_reg[7:0], partial_reg[15:8], byte_reg};
        end
        if (state_reg == ST_PIX_RD) begin
            rd_data_reg <= pal_mem[idx8[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_HEADER;
            file_off_reg  <= '0;
            hshift_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            bpp_reg       <= '0;
            pal_cnt_reg   <= '0;
            dib_size_reg  <= '0;
            data_off_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            rbc_reg       <= '0;
            mod3_reg      <= '0;
            pal_k_reg     <= '0;
            pal_ent_reg   <= '0;
            partial_reg   <= '0;
            any_alpha_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        byte_reg <= s_file_byte;
                        if (s_start_req) begin
                            phase_reg     <= PH_HEADER;
                            p_reg         <= '0;
                            file_off_reg  <= 32'd1;
                            hshift_reg    <= '0;
                            width_reg     <= '0;
                            height_reg    <= '0;
                            bpp_reg       <= '0;
                            pal_cnt_reg   <= '0;
                            dib_size_reg  <= '0;
                            data_off_reg  <= '0;
                            col_reg       <= '0;
                            row_reg       <= '0;
                            rbc_reg       <= '0;
                            mod3_reg      <= '0;
                            pal_k_reg     <= '0;
                            pal_ent_reg   <= '0;
                            partial_reg   <= '0;
                            any_alpha_reg <= 1'b0;
                        end else begin
                            p_reg        <= file_off_reg;
                            file_off_reg <= file_off_reg + 32'd1;
                        end
                    end
                end
                ST_PROC: begin
                    j_reg      <= '0;
                    direct_reg <= 1'b0;
                    unique case (phase_reg)
                        PH_HEADER: begin
                            hshift_reg <= hs_new;
                            if (sig_bad) begin
                                err_reg   <= STATUS_BAD_SIG;
                                phase_reg <= PH_IDLE;
                            end
                            if (hdr_bad) begin
                                err_reg   <= STATUS_BAD_HDR;
                                phase_reg <= PH_IDLE;
                            end else if (p_reg == POS_LAST) begin
                                phase_reg <= PH_DIBSKIP;
                            end
                            if (p_reg == POS_DATAOFF) data_off_reg <= hs_new;
                            if (p_reg == POS_DIBSIZE) dib_size_reg <= hs_new;
                            if (p_reg == POS_WIDTH)   width_reg    <= dim_check(hs_new);
                            if (p_reg == POS_HEIGHT)  height_reg   <= dim_check(hs_new);
                            if (p_reg == POS_BPP) begin
                                if (hs_new[31:16] == 16'd1 || hs_new[31:16] == 16'd4 ||
                                    hs_new[31:16] == 16'd8 || hs_new[31:16] == 16'd24 ||
                                    hs_new[31:16] == 16'd32) begin
                                    bpp_reg <= hs_new[21:16];
                                end else begin
                                    bpp_reg <= '0;
                                end
                            end
                            if (p_reg == POS_PALCNT) begin
                                pal_cnt_reg <= '0;
                                if (small_bpp) begin
                                    if (hs_new == 32'd0) begin
                                        pal_cnt_reg <= 9'(32'd1 << bpp_reg);
                                        if ((32'd1 << bpp_reg) > 32'(PALETTE_DEPTH)) begin
                                            bpp_reg     <= '0;
                                            pal_cnt_reg <= '0;
                                        end
                                    end else if (hs_new > 32'(PALETTE_DEPTH)) begin
                                        bpp_reg <= '0;
                                    end else begin
                                        pal_cnt_reg <= hs_new[8:0];
                                    end
                                end
                            end
                        end
                        PH_PALETTE: begin
                            unique case (pal_k_reg)
                                2'd0:    partial_reg <= {16'd0, byte_reg};
                                2'd1:    partial_reg[15:8]  <= byte_reg;
                                2'd2:    partial_reg[23:16] <= byte_reg;
                                default: pal_ent_reg <= pal_ent_reg + 8'd1;
                            endcase
                            pal_k_reg <= pal_k_reg + 2'd1;
                        end
                        PH_PIXELS: begin
                            unique case (bpp_reg)
                                6'd1: jlast_reg <= 3'd7;
                                6'd4: jlast_reg <= 3'd1;
                                default: jlast_reg <= 3'd0;
                            endcase
                            if (bpp_reg == 6'd24) begin
                                direct_reg   <= 1'b1;
                                px_alpha_reg <= 1'b0;
                                unique case (mod3_reg)
                                    2'd0:    partial_reg <= {16'd0, byte_reg};
                                    2'd1:    partial_reg[15:8] <= byte_reg;
                                    default: partial_reg[23:16] <= byte_reg;
                                endcase
                                pix_reg <= {8'hff, partial_reg[7:0], partial_reg[15:8], byte_reg};
                            end
                            if (bpp_reg == 6'd32) begin
                                direct_reg <= 1'b1;
                                unique case (rbc_reg[1:0])
                                    2'd0:    partial_reg <= {16'd0, byte_reg};
                                    2'd1:    partial_reg[15:8]  <= byte_reg;
                                    2'd2:    partial_reg[23:16] <= byte_reg;
                                    default: begin
                                        if (col_reg < width_reg && byte_reg != 8'd0) begin
                                            any_alpha_reg <= 1'b1;
                                        end
                                        px_alpha_reg <= any_alpha_reg || (byte_reg != 8'd0);
                                    end
                                endcase
                                pix_reg <= {byte_reg, partial_reg[7:0], partial_reg[15:8],
                                            partial_reg[23:16]};
                            end
                        end
                        default: ;
                    endcase
                end
                ST_PIX_RD: begin
                    oob_reg <= ({1'b0, idx8} >= 9'(PALETTE_DEPTH));
                end
                ST_PIX_OUT: begin
                    if (out_free) begin
                        m_status_reg <= STATUS_PIXEL;
                        m_abgr_reg   <= direct_reg ? pix_reg :
                                        (oob_reg ? OPAQUE : {8'hff, rd_data_reg});
                        m_col_reg    <= 12'(col_reg);
                        m_row_reg    <= 12'(height_reg - DIM_W'(1) - row_reg);
                        m_alpha_reg  <= direct_reg && px_alpha_reg;
                        m_done_reg   <= done;
                        m_last_reg   <= px_last;
                        col_reg      <= col_reg + DIM_W'(1);
                        j_reg        <= j_reg + 3'd1;
                        if (done) phase_reg <= PH_IDLE;
                    end
                end
                ST_ROW: begin
                    if (PW'(rbc_reg) + PW'(1) >= stride_reg) begin
                        rbc_reg  <= '0;
                        mod3_reg <= '0;
                        col_reg  <= '0;
                        row_reg  <= row_reg + DIM_W'(1);
                    end else begin
                        rbc_reg  <= rbc_reg + RBC_W'(1);
                        mod3_reg <= (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
                    end
                end
                ST_LIM1: begin
                    dib_end_reg <= HEADER_BYTES +
                                   ((dib_size_reg > BASE_DIB) ?
                                    {1'b0, dib_size_reg - BASE_DIB} : 33'd0);
                    stride_reg  <= stride_calc;
                end
                ST_LIM2: begin
                    pal_end_reg <= {1'b0, dib_end_reg} + {23'd0, pal_cnt_reg, 2'b00};
                end
                ST_SETTLE: begin
                    priority if (phase_reg == PH_DIBSKIP && {1'b0, file_off_reg} >= dib_end_reg)
                        phase_reg <= PH_PALETTE;
                    else if (phase_reg == PH_PALETTE && {2'b0, file_off_reg} >= pal_end_reg)
                        phase_reg <= PH_GAP;
                    else if (phase_reg == PH_GAP && file_off_reg >= data_off_reg)
                        phase_reg <= PH_PIXELS;
                    else ;
                end
                ST_ERR: begin
                    if (out_free) begin
                        m_status_reg <= err_reg;
                        m_abgr_reg   <= '0;
                        m_col_reg    <= '0;
                        m_row_reg    <= '0;
                        m_alpha_reg  <= 1'b0;
                        m_done_reg   <= 1'b0;
                        m_last_reg   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    `BSD_ASSERT(a_err_last, m_valid && m_status != STATUS_PIXEL |-> m_last, "error item not last")
    `BSD_ASSERT(a_err_zero, m_valid && m_status != STATUS_PIXEL |-> m_pixel_abgr == 32'd0 && !m_image_done, "error item carries data")
    `BSD_ASSERT(a_done_last, m_valid && m_image_done |-> m_last, "final pixel not last")
    `BSD_ASSERT_NEXT(a_busy, s_valid && s_ready, !s_ready, "ready straight after accept")

endmodule
